FILE: design/rpsa_pkg.sv
// ----------------------------------------------------------------------------
// rpsa_pkg
// Shared types and constants of the RC PWM to servo angle decoder.
// ----------------------------------------------------------------------------
package rpsa_pkg;

	// timestamp, pulse width, angle and band sizes
	localparam int TS_BITS    = 32;
	localparam int PW_BITS    = 12;
	localparam int ANG_BITS   = 9;
	localparam int BAND_BITS  = 8;

	// pulse window (exclusive) and mapping span in microseconds
	localparam logic [TS_BITS-1:0] PW_MIN_EXCL = TS_BITS'(800);
	localparam logic [TS_BITS-1:0] PW_MAX_EXCL = TS_BITS'(2200);
	localparam int PULSE_LOW  = 1000;
	localparam int PULSE_SPAN = 1000;

	// reciprocal of the span: floor(2^20 / 1000), one correction step after it
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / PULSE_SPAN;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_X_LOW    = 3'd0,
		REG_X_HIGH   = 3'd1,
		REG_X_CENTER = 3'd2,
		REG_Y_LOW    = 3'd3,
		REG_Y_HIGH   = 3'd4,
		REG_Y_CENTER = 3'd5,
		REG_X_BAND   = 3'd6,
		REG_Y_BAND   = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [ANG_BITS-1:0]  RST_X_LOW    = 9'd90;
	localparam logic [ANG_BITS-1:0]  RST_X_HIGH   = 9'd210;
	localparam logic [ANG_BITS-1:0]  RST_X_CENTER = 9'd150;
	localparam logic [ANG_BITS-1:0]  RST_Y_LOW    = 9'd10;
	localparam logic [ANG_BITS-1:0]  RST_Y_HIGH   = 9'd80;
	localparam logic [ANG_BITS-1:0]  RST_Y_CENTER = 9'd45;
	localparam logic [BAND_BITS-1:0] RST_X_BAND   = 8'd8;
	localparam logic [BAND_BITS-1:0] RST_Y_BAND   = 8'd4;

	// configuration seen by the back end
	typedef struct packed {
		logic [ANG_BITS-1:0]  x_low;
		logic [ANG_BITS-1:0]  x_high;
		logic [ANG_BITS-1:0]  x_center;
		logic [ANG_BITS-1:0]  y_low;
		logic [ANG_BITS-1:0]  y_high;
		logic [ANG_BITS-1:0]  y_center;
		logic [BAND_BITS-1:0] x_band;
		logic [BAND_BITS-1:0] y_band;
	} cfg_t;

	// snapshot of both stored widths after one event
	typedef struct packed {
		logic [PW_BITS-1:0] w_y;
		logic [PW_BITS-1:0] w_x;
	} widths_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qctl_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

endpackage

FILE: design/rpsa_regs.sv
// ----------------------------------------------------------------------------
// rpsa_regs
// APB register file holding the angle ranges, centers and deadbands.
// ----------------------------------------------------------------------------
module rpsa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpsa_pkg::APB_AW-1:0]  paddr,
	input  logic [rpsa_pkg::APB_DW-1:0]  pwdata,
	output logic [rpsa_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output rpsa_pkg::cfg_t               cfg
);
	import rpsa_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low    <= RST_X_LOW;
			cfg_q.x_high   <= RST_X_HIGH;
			cfg_q.x_center <= RST_X_CENTER;
			cfg_q.y_low    <= RST_Y_LOW;
			cfg_q.y_high   <= RST_Y_HIGH;
			cfg_q.y_center <= RST_Y_CENTER;
			cfg_q.x_band   <= RST_X_BAND;
			cfg_q.y_band   <= RST_Y_BAND;
		end else if (wr_en) begin
			case (idx)
				REG_X_LOW:    cfg_q.x_low    <= pwdata[ANG_BITS-1:0];
				REG_X_HIGH:   cfg_q.x_high   <= pwdata[ANG_BITS-1:0];
				REG_X_CENTER: cfg_q.x_center <= pwdata[ANG_BITS-1:0];
				REG_Y_LOW:    cfg_q.y_low    <= pwdata[ANG_BITS-1:0];
				REG_Y_HIGH:   cfg_q.y_high   <= pwdata[ANG_BITS-1:0];
				REG_Y_CENTER: cfg_q.y_center <= pwdata[ANG_BITS-1:0];
				REG_X_BAND:   cfg_q.x_band   <= pwdata[BAND_BITS-1:0];
				REG_Y_BAND:   cfg_q.y_band   <= pwdata[BAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_X_LOW:    prdata = APB_DW'(cfg_q.x_low);
			REG_X_HIGH:   prdata = APB_DW'(cfg_q.x_high);
			REG_X_CENTER: prdata = APB_DW'(cfg_q.x_center);
			REG_Y_LOW:    prdata = APB_DW'(cfg_q.y_low);
			REG_Y_HIGH:   prdata = APB_DW'(cfg_q.y_high);
			REG_Y_CENTER: prdata = APB_DW'(cfg_q.y_center);
			REG_X_BAND:   prdata = APB_DW'(cfg_q.x_band);
			REG_Y_BAND:   prdata = APB_DW'(cfg_q.y_band);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: design/rpsa_front.sv
// ----------------------------------------------------------------------------
// rpsa_front
// Edge event intake: records rise times, measures and filters pulse widths,
// and pushes a snapshot of both widths for every accepted event.
// ----------------------------------------------------------------------------
module rpsa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rpsa_pkg::TS_BITS-1:0]  s_tdata,   // [31:0] time_us
	input  logic [1:0]                    s_tuser,   // [0] channel, [1] level
	input  rpsa_pkg::qctl_t               q_stat,
	output logic                          q_push,
	output rpsa_pkg::widths_t             q_wdata
);
	import rpsa_pkg::*;

	logic [TS_BITS-1:0] rise_q [2];
	logic [PW_BITS-1:0] width_q [2];
	logic [PW_BITS-1:0] width_nxt [2];
	logic [TS_BITS-1:0] delta;
	logic               chan;
	logic               rising;
	logic               in_win;
	logic               accept;

	assign chan     = s_tuser[0];
	assign rising   = s_tuser[1];
	assign s_tready = ~q_stat.full;
	assign accept   = s_tvalid & s_tready;

	// width measurement, modulo the timestamp wrap
	assign delta  = s_tdata - rise_q[chan];
	assign in_win = (delta > PW_MIN_EXCL) && (delta < PW_MAX_EXCL);

	always_comb begin
		width_nxt[0] = width_q[0];
		width_nxt[1] = width_q[1];
		if (!rising && in_win)
			width_nxt[chan] = delta[PW_BITS-1:0];
	end

	// state update on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q[0]  <= '0;
			rise_q[1]  <= '0;
			width_q[0] <= '0;
			width_q[1] <= '0;
		end else if (accept) begin
			if (rising)
				rise_q[chan] <= s_tdata;
			width_q[0] <= width_nxt[0];
			width_q[1] <= width_nxt[1];
		end
	end

	assign q_push      = accept;
	assign q_wdata.w_x = width_nxt[0];
	assign q_wdata.w_y = width_nxt[1];

endmodule

FILE: design/rpsa_queue.sv
// ----------------------------------------------------------------------------
// rpsa_queue
// Small FIFO of width snapshots between the front and the back end.
// ----------------------------------------------------------------------------
module rpsa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rpsa_pkg::widths_t wdata,
	input  logic              pop,
	output rpsa_pkg::widths_t rdata,
	output rpsa_pkg::qctl_t   stat
);
	import rpsa_pkg::*;

	widths_t         mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign rdata      = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wdata;
	end

endmodule

FILE: design/rpsa_back.sv
// ----------------------------------------------------------------------------
// rpsa_back
// Angle pipeline: linear map with truncating division by the span,
// clamp and deadband snap, then the output register.
// ----------------------------------------------------------------------------
module rpsa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rpsa_pkg::cfg_t    cfg,
	input  rpsa_pkg::qctl_t   q_stat,
	output logic              q_pop,
	input  rpsa_pkg::widths_t q_rdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [8:0] angle_x, [17:9] angle_y, rest zero
	output logic              m_tuser    // [0] ready_res
);
	import rpsa_pkg::*;

	// per-channel configuration views
	logic [ANG_BITS-1:0]  out_a [2];
	logic [ANG_BITS-1:0]  out_b [2];
	logic [ANG_BITS-1:0]  lo [2];
	logic [ANG_BITS-1:0]  hi [2];
	logic [ANG_BITS-1:0]  ctr [2];
	logic [BAND_BITS-1:0] band [2];
	logic [PW_BITS-1:0]   w_in [2];

	logic                 adv;
	logic                 valid_s1, valid_s2, valid_s3, m_valid_q;
	logic                 rdy_s1, rdy_s2, rdy_s3, rdy_q;

	logic signed [12:0]   dw [2];
	logic signed [9:0]    span [2];
	logic signed [22:0]   prod_s1 [2];

	logic [22:0]          mag_full [2];
	logic                 neg_s2 [2];
	logic [18:0]          mag_s2 [2];
	logic [29:0]          est_s2 [2];

	logic [9:0]           q0 [2];
	logic [19:0]          rem [2];
	logic [9:0]           quo [2];
	logic signed [11:0]   squo [2];
	logic signed [11:0]   val_s3 [2];

	logic signed [11:0]   clamped [2];
	logic signed [11:0]   diff [2];
	logic [11:0]          adiff [2];
	logic [ANG_BITS-1:0]  shaped [2];
	logic [ANG_BITS-1:0]  ang_q [2];

	// X runs from x_high at the short pulse down to x_low; Y runs upward
	assign out_a[0] = cfg.x_high;
	assign out_b[0] = cfg.x_low;
	assign out_a[1] = cfg.y_low;
	assign out_b[1] = cfg.y_high;
	assign lo[0]    = cfg.x_low;
	assign hi[0]    = cfg.x_high;
	assign ctr[0]   = cfg.x_center;
	assign band[0]  = cfg.x_band;
	assign lo[1]    = cfg.y_low;
	assign hi[1]    = cfg.y_high;
	assign ctr[1]   = cfg.y_center;
	assign band[1]  = cfg.y_band;
	assign w_in[0]  = q_rdata.w_x;
	assign w_in[1]  = q_rdata.w_y;

	// whole pipeline moves unless the output holds an untaken result
	assign adv   = ~m_valid_q | m_tready;
	assign q_pop = adv & ~q_stat.empty;

	// stage 1: offset width times output span
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			dw[c]   = $signed({1'b0, w_in[c]}) - 13'sd1000;
			span[c] = $signed({1'b0, out_b[c]}) - $signed({1'b0, out_a[c]});
		end
	end

	// stage 2: magnitude times reciprocal of the span
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mag_full[c] = prod_s1[c][22] ? 23'(-prod_s1[c]) : 23'(prod_s1[c]);
		end
	end

	// stage 3: quotient with one correction step, sign back, add base
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			q0[c]   = est_s2[c][29:RECIP_SHIFT];
			rem[c]  = {1'b0, mag_s2[c]} - 20'({10'b0, q0[c]} * 20'(PULSE_SPAN));
			quo[c]  = (rem[c] >= 20'(PULSE_SPAN)) ? q0[c] + 10'd1 : q0[c];
			squo[c] = neg_s2[c] ? -$signed({2'b0, quo[c]}) : $signed({2'b0, quo[c]});
		end
	end

	// stage 4: clamp to [low, high], snap to center inside the deadband
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (val_s3[c] < $signed({3'b0, lo[c]}))
				clamped[c] = $signed({3'b0, lo[c]});
			else if (val_s3[c] > $signed({3'b0, hi[c]}))
				clamped[c] = $signed({3'b0, hi[c]});
			else
				clamped[c] = val_s3[c];
			diff[c]  = clamped[c] - $signed({3'b0, ctr[c]});
			adiff[c] = diff[c][11] ? 12'(-diff[c]) : 12'(diff[c]);
			if (adiff[c] < {4'b0, band[c]})
				shaped[c] = ctr[c];
			else
				shaped[c] = clamped[c][ANG_BITS-1:0];
		end
	end

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1  <= q_pop;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			m_valid_q <= valid_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			rdy_s1 <= (q_rdata.w_x != '0) && (q_rdata.w_y != '0);
			rdy_s2 <= rdy_s1;
			rdy_s3 <= rdy_s2;
			rdy_q  <= rdy_s3;
			for (int c = 0; c < 2; c++) begin
				prod_s1[c] <= 23'(dw[c] * span[c]);
				neg_s2[c]  <= prod_s1[c][22];
				mag_s2[c]  <= mag_full[c][18:0];
				est_s2[c]  <= 30'({11'b0, mag_full[c][18:0]} * 30'(RECIP_MUL));
				val_s3[c]  <= squo[c] + $signed({3'b0, out_a[c]});
				ang_q[c]   <= shaped[c];
			end
		end
	end

	// result fields are zero until both channels hold a width
	assign m_tvalid = m_valid_q;
	assign m_tuser  = rdy_q;
	assign m_tdata  = rdy_q ? {6'b0, ang_q[1], ang_q[0]} : 24'b0;

endmodule

FILE: design/rc_pwm_to_servo_angle.sv
// ----------------------------------------------------------------------------
// rc_pwm_to_servo_angle
// Two-channel RC PWM pulse width decoder producing servo angles.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  s_      | in  | tdata[31:0] time_us; tuser[0] channel,    | tvalid/tready
//          |     | tuser[1] level                            |
//  m_      | out | tdata[8:0] angle_x, [17:9] angle_y;       | tvalid/tready
//          |     | tuser[0] ready_res                        |
//  apb     | in  | 8 registers at byte address 4*i           | psel/penable
//
//  One event per clock cycle while the queue is not full; each event gives
//  one result, through the 4-entry queue and a four-stage angle pipeline.
//  Reset (arst_n low) clears rise times, widths and the queue and loads the
//  register defaults. A stalled output holds the pipeline; events are still
//  taken until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module rc_pwm_to_servo_angle (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rpsa_pkg::TS_BITS-1:0] s_tdata,   // [31:0] time_us
	input  logic [1:0]                   s_tuser,   // [0] channel, [1] level
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [8:0] angle_x, [17:9] angle_y
	output logic                         m_tuser,   // [0] ready_res
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpsa_pkg::APB_AW-1:0]  paddr,
	input  logic [rpsa_pkg::APB_DW-1:0]  pwdata,
	output logic [rpsa_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import rpsa_pkg::*;

	cfg_t    cfg;
	qctl_t   q_stat;
	widths_t q_wdata;
	widths_t q_rdata;
	logic    q_push;
	logic    q_pop;

	rpsa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpsa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	rpsa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	rpsa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.q_rdata  (q_rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
